@@ hw/rtl/text_console_cell_writer_assert.svh @@
// Assertion macros for the text console cell writer.
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCW_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("text console cell writer: check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("text console cell writer: check failed");

`endif

@@ hw/rtl/tccw_pkg.sv @@
// Shared constants and types of the text console cell writer.
`default_nettype none

package tccw_pkg;

  localparam int unsigned DefColumns = 80;
  localparam int unsigned DefRows    = 25;
  localparam int unsigned TabStep    = 8;
  localparam int unsigned InW        = 32;
  localparam int unsigned OutW       = 40;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_SET   = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [7:0] FillReset = 8'd7;

  typedef struct packed {
    logic we;
    logic scroll;
  } tccw_put_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/tccw_cursor.sv @@
// Cursor movement and cell write for a put action.
`default_nettype none

module tccw_cursor #(
  parameter int unsigned COLUMNS = tccw_pkg::DefColumns,
  parameter int unsigned ROWS    = tccw_pkg::DefRows
) (
  input  logic [$clog2(COLUMNS)-1:0] cur_col_i,
  input  logic [$clog2(ROWS)-1:0]    cur_row_i,
  input  logic [7:0]                 char_code_i,
  input  logic [7:0]                 attribute_i,
  input  logic [7:0]                 fill_i,
  output logic [$clog2(COLUMNS)-1:0] col_o,
  output logic [$clog2(ROWS)-1:0]    row_o,
  output logic [$clog2(COLUMNS)-1:0] wcol_o,
  output logic [$clog2(ROWS)-1:0]    wrow_o,
  output logic [15:0]                wdata_o,
  output tccw_pkg::tccw_put_ctl_t    ctl_o
);
  import tccw_pkg::*;

  localparam int unsigned ColW = $clog2(COLUMNS);
  localparam int unsigned RowW = $clog2(ROWS);
  localparam logic [ColW-1:0] LastCol = ColW'(COLUMNS - 1);
  localparam logic [RowW-1:0] LastRow = RowW'(ROWS - 1);

  logic [ColW:0]   tab_sum;
  logic [RowW-1:0] nl_row;
  logic            nl_scroll;

  assign tab_sum   = ({1'b0, cur_col_i} + (ColW+1)'(TabStep)) & ~((ColW+1)'(TabStep - 1));
  assign nl_scroll = (cur_row_i == LastRow);
  assign nl_row    = nl_scroll ? LastRow : cur_row_i + RowW'(1);

  always_comb begin
    col_o   = cur_col_i;
    row_o   = cur_row_i;
    wdata_o = {attribute_i, char_code_i};
    ctl_o   = '0;
    unique case (char_code_i)
      CH_NEWLINE: begin
        col_o        = '0;
        row_o        = nl_row;
        ctl_o.scroll = nl_scroll;
      end
      CH_RETURN: begin
        col_o = '0;
      end
      CH_TAB: begin
        if (tab_sum >= (ColW+1)'(COLUMNS)) begin
          col_o        = '0;
          row_o        = nl_row;
          ctl_o.scroll = nl_scroll;
        end else begin
          col_o = tab_sum[ColW-1:0];
        end
      end
      CH_BACKSPACE: begin
        if (cur_col_i != '0) begin
          col_o = cur_col_i - ColW'(1);
        end else if (cur_row_i != '0) begin
          row_o = cur_row_i - RowW'(1);
          col_o = LastCol;
        end
        ctl_o.we = 1'b1;
        wdata_o  = {fill_i, CH_SPACE};
      end
      default: begin
        ctl_o.we = 1'b1;
        if (cur_col_i == LastCol) begin
          col_o        = '0;
          row_o        = nl_row;
          ctl_o.scroll = nl_scroll;
        end else begin
          col_o = cur_col_i + ColW'(1);
        end
      end
    endcase
  end

  // Backspace blanks the cell it lands on; any other character that is stored goes where the cursor was.
  assign wcol_o = (char_code_i == CH_BACKSPACE) ? col_o : cur_col_i;
  assign wrow_o = (char_code_i == CH_BACKSPACE) ? row_o : cur_row_i;

endmodule

`default_nettype wire

@@ hw/rtl/text_console_cell_writer.sv @@
// Top level of the text console cell writer: screen memory, sequencer and stream ports.
`default_nettype none

// The screen lives in one single-port-write, single-port-read memory of COLUMNS*ROWS
// words with a registered read. After reset the block sweeps the memory, one word a
// cycle, writing blanks of attribute 7 with s_axis_tready low; configuration writes
// are taken during the sweep. A set-cursor action or a put that does not scroll gives
// its result word in the cycle after acceptance, and another word may be accepted
// every cycle while the output is free or taken; a read action goes through S_READ,
// which loads the registered memory word. A clear blanks every word; a scrolling put
// moves each row up, then blanks the bottom row, at one memory write per cycle.
`include "text_console_cell_writer_assert.svh"

module text_console_cell_writer #(
  parameter int unsigned COLUMNS = tccw_pkg::DefColumns,
  parameter int unsigned ROWS    = tccw_pkg::DefRows
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [7:0]                cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // action[1:0], char_code[9:2], attribute[17:10], pos_x[24:18], pos_y[29:25], zero pad
  input  logic [tccw_pkg::InW-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // cursor_col[6:0], cursor_row[11:7], cursor_linear[22:12], cell_word[38:23], did_scroll[39]
  output logic [tccw_pkg::OutW-1:0] m_axis_tdata
);
  import tccw_pkg::*;

  localparam int unsigned Cells     = COLUMNS * ROWS;
  localparam int unsigned MoveCells = (ROWS - 1) * COLUMNS;
  localparam int unsigned AddrW     = $clog2(Cells);
  localparam int unsigned ColW      = $clog2(COLUMNS);
  localparam int unsigned RowW      = $clog2(ROWS);
  localparam int unsigned XW        = (ColW > 7) ? ColW : 7;
  localparam int unsigned YW        = (RowW > 5) ? RowW : 5;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_INIT  = 3'd4;

  function automatic logic [AddrW-1:0] lin(input logic [RowW-1:0] r, input logic [ColW-1:0] c);
    lin = AddrW'(r) * AddrW'(COLUMNS) + AddrW'(c);
  endfunction

  logic [1:0] in_action;
  logic [7:0] in_char;
  logic [7:0] in_attr;
  logic [6:0] in_pos_x;
  logic [4:0] in_pos_y;

  assign in_action = s_axis_tdata[1:0];
  assign in_char   = s_axis_tdata[9:2];
  assign in_attr   = s_axis_tdata[17:10];
  assign in_pos_x  = s_axis_tdata[24:18];
  assign in_pos_y  = s_axis_tdata[29:25];

  logic [XW-1:0]   px_ext;
  logic [YW-1:0]   py_ext;
  logic [ColW-1:0] px;
  logic [RowW-1:0] py;

  assign px_ext = XW'(in_pos_x);
  assign py_ext = YW'(in_pos_y);
  assign px = (px_ext > XW'(COLUMNS - 1)) ? ColW'(COLUMNS - 1) : ColW'(px_ext);
  assign py = (py_ext > YW'(ROWS - 1)) ? RowW'(ROWS - 1) : RowW'(py_ext);

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic             pend_q, pend_d;
  logic             scroll_q, scroll_d;
  logic [ColW-1:0]  cur_col_q, cur_col_d;
  logic [RowW-1:0]  cur_row_q, cur_row_d;
  logic [7:0]       fill_q;

  logic             out_valid_q, out_valid_d;
  logic [OutW-1:0]  out_data_q, out_data_d;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [15:0]      rd_data_q;
  logic [15:0]      screen_mem [Cells];

  logic            load;
  logic [15:0]     ld_cell;
  logic            ld_scroll;
  logic [AddrW-1:0] cur_lin;
  logic            accept;

  logic [ColW-1:0]  put_col, put_wcol;
  logic [RowW-1:0]  put_row, put_wrow;
  logic [15:0]      put_wdata;
  tccw_put_ctl_t    put_ctl;

  tccw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .cur_col_i   (cur_col_q),
    .cur_row_i   (cur_row_q),
    .char_code_i (in_char),
    .attribute_i (in_attr),
    .fill_i      (fill_q),
    .col_o       (put_col),
    .row_o       (put_row),
    .wcol_o      (put_wcol),
    .wrow_o      (put_wrow),
    .wdata_o     (put_wdata),
    .ctl_o       (put_ctl)
  );

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    pend_d    = 1'b0;
    scroll_d  = scroll_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    load      = 1'b0;
    ld_cell   = '0;
    ld_scroll = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_PUT: begin
              cur_col_d = put_col;
              cur_row_d = put_row;
              mem_we    = put_ctl.we;
              mem_waddr = lin(put_wrow, put_wcol);
              mem_wdata = put_wdata;
              scroll_d  = 1'b1;
              if (put_ctl.scroll) begin
                state_d = S_SHIFT;
                ptr_d   = '0;
              end else begin
                load = 1'b1;
              end
            end
            ACT_CLEAR: begin
              cur_col_d = '0;
              cur_row_d = '0;
              scroll_d  = 1'b0;
              ptr_d     = '0;
              state_d   = S_FILL;
            end
            ACT_SET: begin
              cur_col_d = px;
              cur_row_d = py;
              load      = 1'b1;
            end
            ACT_READ: begin
              mem_re    = 1'b1;
              mem_raddr = lin(py, px);
              state_d   = S_READ;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        load    = 1'b1;
        ld_cell = rd_data_q;
        state_d = S_IDLE;
      end
      S_SHIFT: begin
        // Each row moves up one: read a row below, write the word back one row higher.
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_q - AddrW'(1);
          mem_wdata = rd_data_q;
        end
        if (ptr_q != AddrW'(MoveCells)) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + AddrW'(COLUMNS);
          ptr_d     = ptr_q + AddrW'(1);
          pend_d    = 1'b1;
        end else begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = {fill_q, CH_SPACE};
        if (ptr_q == AddrW'(Cells - 1)) begin
          load      = 1'b1;
          ld_scroll = scroll_q;
          state_d   = S_IDLE;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = {FillReset, CH_SPACE};
        if (ptr_q == AddrW'(Cells - 1)) begin
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cur_lin = lin(cur_row_d, cur_col_d);

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_data_d  = {ld_scroll, ld_cell, 11'(cur_lin), 5'(cur_row_d), 7'(cur_col_d)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      scroll_q    <= 1'b0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      fill_q      <= FillReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      scroll_q    <= scroll_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        fill_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= screen_mem[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `TCCW_ASSERT_SAME(a_cursor_range, 1'b1,
                    (cur_col_q <= ColW'(COLUMNS - 1)) && (cur_row_q <= RowW'(ROWS - 1)))
  `TCCW_ASSERT_SAME(a_waddr_range, mem_we, mem_waddr <= AddrW'(Cells - 1))
  `TCCW_ASSERT_NEXT(a_read_path, accept && (in_action == ACT_READ), state_q == S_READ)
  `TCCW_ASSERT_SAME(a_busy_stalls, state_q != S_IDLE, !s_axis_tready)

endmodule

`default_nettype wire

@@ tb/text_console_cell_writer_tb.sv @@
// Self-checking testbench for the text console cell writer.
module text_console_cell_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  localparam int unsigned COLS        = DefColumns;
  localparam int unsigned ROWS_N      = DefRows;
  localparam int unsigned CELL_COUNT  = COLS * ROWS_N;
  localparam int          QUIET_LIMIT = 20000;
  localparam int          PRINT_CAP   = 40;

  typedef struct packed {
    logic [1:0] pad;
    logic [4:0] pos_y;
    logic [6:0] pos_x;
    logic [7:0] attr;
    logic [7:0] glyph;
    logic [1:0] act;
  } console_item_t;

  typedef struct packed {
    logic        did_scroll;
    logic [15:0] cell_word;
    logic [10:0] cursor_linear;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } cursor_report_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [7:0]      cfg_wdata_i;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [OutW-1:0] m_axis_tdata;

  logic [15:0]    shadow_screen [CELL_COUNT];
  int unsigned    shadow_col;
  int unsigned    shadow_row;
  logic [7:0]     shadow_fill;
  cursor_report_t cursor_reports_q [$];

  int mismatch_count;
  int quiet_cycles;
  int feed_mode;
  int sink_mode;
  int hold_request;
  int stall_left;

  text_console_cell_writer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int idle_len(int mode);
    int r;
    if (mode == 0) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(3, 1);
    end else if (r < 97) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(60, 20);
  endfunction

  function automatic logic line_feed();
    int unsigned i;
    shadow_col = 0;
    shadow_row++;
    if (shadow_row < ROWS_N) begin
      return 1'b0;
    end
    for (i = 0; i < (ROWS_N - 1) * COLS; i++) begin
      shadow_screen[i] = shadow_screen[i + COLS];
    end
    for (i = (ROWS_N - 1) * COLS; i < CELL_COUNT; i++) begin
      shadow_screen[i] = {shadow_fill, CH_SPACE};
    end
    shadow_row = ROWS_N - 1;
    return 1'b1;
  endfunction

  function automatic logic put_glyph(logic [7:0] glyph, logic [7:0] attr);
    case (glyph)
      CH_NEWLINE: begin
        return line_feed();
      end
      CH_RETURN: begin
        shadow_col = 0;
        return 1'b0;
      end
      CH_TAB: begin
        shadow_col = (shadow_col + TabStep) & ~(TabStep - 1);
        if (shadow_col >= COLS) begin
          return line_feed();
        end
        return 1'b0;
      end
      CH_BACKSPACE: begin
        if (shadow_col > 0) begin
          shadow_col--;
        end else if (shadow_row > 0) begin
          shadow_row--;
          shadow_col = COLS - 1;
        end
        shadow_screen[shadow_row * COLS + shadow_col] = {shadow_fill, CH_SPACE};
        return 1'b0;
      end
      default: begin
        shadow_screen[shadow_row * COLS + shadow_col] = {attr, glyph};
        shadow_col++;
        if (shadow_col >= COLS) begin
          return line_feed();
        end
        return 1'b0;
      end
    endcase
  endfunction

  function automatic cursor_report_t advance_console(console_item_t it);
    cursor_report_t r;
    int unsigned    px;
    int unsigned    py;
    int unsigned    i;
    px = (it.pos_x > COLS - 1) ? COLS - 1 : it.pos_x;
    py = (it.pos_y > ROWS_N - 1) ? ROWS_N - 1 : it.pos_y;
    r = '0;
    case (it.act)
      ACT_PUT: begin
        r.did_scroll = put_glyph(it.glyph, it.attr);
      end
      ACT_CLEAR: begin
        for (i = 0; i < CELL_COUNT; i++) begin
          shadow_screen[i] = {shadow_fill, CH_SPACE};
        end
        shadow_col = 0;
        shadow_row = 0;
      end
      ACT_SET: begin
        shadow_col = px;
        shadow_row = py;
      end
      default: begin
        r.cell_word = shadow_screen[py * COLS + px];
      end
    endcase
    r.cursor_col    = 7'(shadow_col);
    r.cursor_row    = 5'(shadow_row);
    r.cursor_linear = 11'(shadow_row * COLS + shadow_col);
    return r;
  endfunction

  function automatic console_item_t make_item(logic [1:0] act, logic [7:0] glyph,
                                              logic [7:0] attr, logic [6:0] pos_x,
                                              logic [4:0] pos_y);
    console_item_t it;
    it.pad   = '0;
    it.act   = act;
    it.glyph = glyph;
    it.attr  = attr;
    it.pos_x = pos_x;
    it.pos_y = pos_y;
    return it;
  endfunction

  // Mostly text with control codes and cursor moves; reads often look at the
  // cell just written so that stored words are seen again.
  function automatic console_item_t random_item();
    console_item_t it;
    int            pick;
    it     = console_item_t'($urandom);
    it.pad = '0;
    pick   = $urandom_range(99);
    if (pick < 50) begin
      it.act = ACT_PUT;
    end else if (pick < 60) begin
      it.act = ACT_PUT;
      case ($urandom_range(3))
        0:       it.glyph = CH_NEWLINE;
        1:       it.glyph = CH_RETURN;
        2:       it.glyph = CH_TAB;
        default: it.glyph = CH_BACKSPACE;
      endcase
    end else if (pick < 72) begin
      it.act = ACT_SET;
      if ($urandom_range(3) != 0) begin
        it.pos_x = 7'($urandom_range(COLS - 1));
        it.pos_y = 5'($urandom_range(ROWS_N - 1));
      end
    end else if (pick < 98) begin
      it.act = ACT_READ;
      if (pick < 86) begin
        it.pos_x = 7'((shadow_col == 0) ? 0 : shadow_col - 1);
        it.pos_y = 5'(shadow_row);
      end
    end else begin
      it.act = ACT_CLEAR;
    end
    return it;
  endfunction

  task automatic report_mismatch(string field, logic [39:0] want, logic [39:0] got);
    if (mismatch_count < PRINT_CAP) begin
      $display("mismatch in %s at %0t: expected %0h, got %0h", field, $time, want, got);
    end
    mismatch_count++;
  endtask

  task automatic check_report(cursor_report_t got);
    cursor_report_t want;
    if (cursor_reports_q.size() == 0) begin
      report_mismatch("unexpected result word", '0, got);
      return;
    end
    want = cursor_reports_q.pop_front();
    if (got.cursor_col !== want.cursor_col) begin
      report_mismatch("cursor_col", 40'(want.cursor_col), 40'(got.cursor_col));
    end
    if (got.cursor_row !== want.cursor_row) begin
      report_mismatch("cursor_row", 40'(want.cursor_row), 40'(got.cursor_row));
    end
    if (got.cursor_linear !== want.cursor_linear) begin
      report_mismatch("cursor_linear", 40'(want.cursor_linear), 40'(got.cursor_linear));
    end
    if (got.cell_word !== want.cell_word) begin
      report_mismatch("cell_word", 40'(want.cell_word), 40'(got.cell_word));
    end
    if (got.did_scroll !== want.did_scroll) begin
      report_mismatch("did_scroll", 40'(want.did_scroll), 40'(got.did_scroll));
    end
  endtask

  // The handshake is judged at the falling edge, where every signal is settled,
  // and takes effect at the rising edge that follows.
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && (m_axis_tvalid & m_axis_tready) === 1'b1) begin
      check_report(cursor_report_t'(m_axis_tdata));
    end
  end

  always @(negedge clk_i) begin
    if ((s_axis_tvalid & s_axis_tready) === 1'b1 || (m_axis_tvalid & m_axis_tready) === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    m_axis_tready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = idle_len(sink_mode);
      end
    end
  end

  task automatic send_item(console_item_t it);
    int gap;
    gap = idle_len(feed_mode);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    @(negedge clk_i);
    while (s_axis_tready !== 1'b1) @(negedge clk_i);
    @(posedge clk_i);
    cursor_reports_q.push_back(advance_console(it));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (cursor_reports_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_fill(logic [7:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_fill = value;
  endtask

  task automatic test_directed();
    feed_mode = 0;
    sink_mode = 0;
    send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    send_item(make_item(ACT_READ, 8'hFF, 8'hFF, 7'd127, 5'd31));
    send_item(make_item(ACT_PUT, 8'h00, 8'hFF, 7'd0, 5'd0));
    send_item(make_item(ACT_PUT, 8'hFF, 8'h00, 7'd127, 5'd31));
    send_item(make_item(ACT_PUT, CH_RETURN, 8'h00, 7'd0, 5'd0));
    send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'd1, 5'd0));
    send_item(make_item(ACT_PUT, CH_BACKSPACE, 8'h00, 7'd0, 5'd0));
    send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    send_item(make_item(ACT_SET, 8'h00, 8'h00, 7'd75, 5'd2));
    send_item(make_item(ACT_PUT, CH_TAB, 8'h00, 7'd0, 5'd0));
    send_item(make_item(ACT_PUT, CH_TAB, 8'h00, 7'd0, 5'd0));
    send_item(make_item(ACT_PUT, CH_BACKSPACE, 8'h00, 7'd0, 5'd0));
    send_item(make_item(ACT_SET, 8'h00, 8'h00, 7'd0, 5'd5));
    send_item(make_item(ACT_PUT, CH_BACKSPACE, 8'h00, 7'd0, 5'd0));
    send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'd79, 5'd4));
    send_item(make_item(ACT_SET, 8'h00, 8'h00, 7'd79, 5'd6));
    send_item(make_item(ACT_PUT, 8'h41, 8'h1E, 7'd0, 5'd0));
    send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'd79, 5'd6));
    send_item(make_item(ACT_SET, 8'h00, 8'h00, 7'd127, 5'd31));
    send_item(make_item(ACT_PUT, 8'h5A, 8'hC3, 7'd0, 5'd0));
    send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'd79, 5'd23));
    send_item(make_item(ACT_PUT, CH_NEWLINE, 8'h00, 7'd0, 5'd0));
    send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'd79, 5'd22));
    send_item(make_item(ACT_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0));
    send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'd40, 5'd12));
  endtask

  // Each fill setting is seen through backspace and scroll blanks, and one of them also through clear blanks.
  task automatic test_fill_attribute();
    logic [7:0] fills [4];
    int         k;
    fills[0] = 8'h00;
    fills[1] = 8'hFF;
    fills[2] = 8'($urandom_range(254, 1));
    fills[3] = FillReset;
    feed_mode = 1;
    sink_mode = 1;
    for (k = 0; k < 4; k++) begin
      set_fill(fills[k]);
      send_item(make_item(ACT_SET, 8'h00, 8'h00, 7'd3, 5'd9));
      send_item(make_item(ACT_PUT, CH_BACKSPACE, 8'h00, 7'd0, 5'd0));
      send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'd2, 5'd9));
      send_item(make_item(ACT_SET, 8'h00, 8'h00, 7'd10, 5'd24));
      send_item(make_item(ACT_PUT, CH_NEWLINE, 8'h00, 7'd0, 5'd0));
      send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'd10, 5'd24));
      send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'd2, 5'd8));
      if (k == 1) begin
        send_item(make_item(ACT_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0));
        send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'd79, 5'd0));
      end
    end
  endtask

  task automatic test_random_traffic(int per_block);
    int blk;
    int n;
    for (blk = 0; blk < 6; blk++) begin
      set_fill(8'($urandom));
      feed_mode = (blk == 1 || blk == 3) ? 0 : 1;
      sink_mode = (blk == 1 || blk == 2) ? 0 : 1;
      for (n = 0; n < per_block; n++) begin
        send_item(random_item());
      end
    end
  endtask

  task automatic test_output_backpressure();
    int n;
    wait_idle();
    feed_mode = 0;
    sink_mode = 0;
    send_item(make_item(ACT_SET, 8'h00, 8'h00, 7'd0, 5'd3));
    hold_request = 300;
    for (n = 0; n < 40; n++) begin
      send_item(make_item(ACT_PUT, 8'($urandom_range(126, 33)), 8'($urandom), 7'd0, 5'd0));
    end
    for (n = 0; n < 8; n++) begin
      send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'(n * 5), 5'd3));
    end
  endtask

  task automatic finish_run();
    s_axis_tvalid <= 1'b0;
    while (cursor_reports_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && cursor_reports_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  endtask

  initial begin
    int unsigned i;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    hold_request   = 0;
    feed_mode      = 0;
    sink_mode      = 0;
    shadow_fill    = FillReset;
    shadow_col     = 0;
    shadow_row     = 0;
    for (i = 0; i < CELL_COUNT; i++) begin
      shadow_screen[i] = {FillReset, CH_SPACE};
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_fill_attribute();
    test_output_backpressure();
    test_random_traffic(200);
    finish_run();
  end

endmodule

@@ text_console_cell_writer.f @@
+incdir+hw/rtl
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_cursor.sv
hw/rtl/text_console_cell_writer.sv
tb/text_console_cell_writer_tb.sv
